/* sv/sme_pkg.sv */
// Package for the stack machine executor: opcodes, status codes, widths and
// controller command/status structures. No dependencies.
package sme_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int TEXT_WORDS = 65536;
    localparam int PC_W       = $clog2(TEXT_WORDS);
    localparam int PTR_W      = 13;

    typedef enum logic [5:0] {
        OP_LEA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_CALL = 6'd3,
        OP_JZ = 6'd4, OP_JNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7,
        OP_LEV = 6'd8, OP_LI = 6'd9, OP_LC = 6'd10, OP_SI = 6'd11,
        OP_SC = 6'd12, OP_PUSH = 6'd13, OP_OR = 6'd14, OP_XOR = 6'd15,
        OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
        OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23,
        OP_SHR = 6'd24, OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27,
        OP_DIV = 6'd28, OP_MOD = 6'd29, OP_EXIT = 6'd37, OP_HWR = 6'd38
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_DIV0 = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD1, S_RD1W, S_RD2, S_RD2W, S_EXEC, S_DIV, S_WR, S_OUT
    } t_state;

    // Memory address sources.
    typedef enum logic [2:0] {
        A_SP, A_SPM1, A_SPP1, A_ACC, A_OPA, A_HOST, A_BP, A_BPP1
    } t_asel;

    typedef struct packed {
        logic  load;       // capture input beat
        logic  rd;         // issue memory read
        t_asel asel;
        logic  cap1;       // capture first read word into operand A
        logic  cap2;       // capture second read word into operand B
        logic  exec;       // commit architectural update
        logic  div_start;
        logic  wr;         // perform memory write
        logic  out_load;   // load output register
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic halted;
        logic div_busy;
        logic div_zero;
        logic out_full;
    } t_sts;

    function automatic logic known_op(input logic [5:0] f);
        return (f <= 6'd29) || f == 6'd37 || f == 6'd38;
    endfunction

endpackage

/* sv/stack_machine_executor_top.sv */
// Stack machine executor top level: controller, LEV address remap, datapath, divider.
// Memory reads and writes, LEV, SC, and DIV and MOD (one-bit-per-cycle divider) pass
// through extra controller states; an instruction also waits while the output register
// stays full. One instruction is in work at a time.
// Synchronous active-low reset: acc and pc zero, pointers 4096, not halted.
module stack_machine_executor_top
    import sme_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: func[5:0], imm[37:6], addr[49:38], zero pad to 56 bits
    input  logic [55:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: acc_value[31:0], next_pc[47:32], stack_index[60:48],
    // exit_value[92:61], status[94:93], zero pad to 96 bits
    output logic [95:0]  m_axis_tdata
);
    t_cmd         w_cmd_ctrl;
    t_cmd         w_cmd;
    t_sts         w_sts;
    logic [95:0]  w_out;
    logic         w_take;

    assign w_take = m_axis_tvalid && m_axis_tready;

    sme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_sts(w_sts), .i_out_take(w_take),
        .o_cmd(w_cmd_ctrl)
    );

    sme_lev u_lev (
        .i_cmd(w_cmd_ctrl), .i_op(w_sts.op), .o_cmd(w_cmd)
    );

    sme_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_func(s_axis_tdata[5:0]),
        .i_imm(s_axis_tdata[37:6]), .i_addr(s_axis_tdata[49:38]),
        .i_cmd(w_cmd), .i_out_take(w_take), .o_sts(w_sts), .o_out(w_out)
    );

    assign m_axis_tvalid = w_sts.out_full;
    assign m_axis_tdata  = w_out;
endmodule

/* sv/sme_div.sv */
// Radix-2 signed divider, one quotient bit per cycle.
// Depends on sme_pkg.
module sme_div
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_busy,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_q, n_q, r_r, n_r, r_d, n_d;
    logic        r_na, n_na, r_nq, n_nq;
    logic [32:0] w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_na <= n_na; r_nq <= n_nq;
    end

    assign w_t = {r_r, r_q[31]} - {1'b0, r_d};

    always_comb begin
        n_cnt = r_cnt; n_q = r_q; n_r = r_r; n_d = r_d; n_na = r_na; n_nq = r_nq;
        if (i_start) begin
            n_cnt = 6'd32;
            n_na  = i_a[31];
            n_nq  = i_a[31] ^ i_b[31];
            n_q   = i_a[31] ? 32'(-i_a) : i_a;
            n_d   = i_b[31] ? 32'(-i_b) : i_b;
            n_r   = '0;
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (!w_t[32]) begin
                n_r = w_t[31:0];
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = {r_r[30:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quo  = r_nq ? 32'(-r_q) : r_q;
    assign o_rem  = r_na ? 32'(-r_r) : r_r;
endmodule

/* sv/sme_datapath.sv */
// Datapath: architectural registers, word memory, ALU, divider, output register.
// Depends on sme_pkg and sme_div.
module sme_datapath
    import sme_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_data,
    input  logic [5:0]   i_func,
    input  logic [31:0]  i_imm,
    input  logic [11:0]  i_addr,
    input  t_cmd         i_cmd,
    input  logic         i_out_take,
    output t_sts         o_sts,
    output logic [95:0]  o_out
);
    logic [31:0]      mem [MEM_WORDS];
    logic [31:0]      r_rdata;
    logic [31:0]      r_acc, n_acc;
    logic [PTR_W-1:0] r_sp, n_sp, r_bp, n_bp;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic             r_halt, n_halt;
    logic [5:0]       r_func;
    logic [31:0]      r_imm, r_opa, r_opb;
    logic [MEM_AW-1:0] r_haddr;
    logic [31:0]      r_exit, n_exit;
    logic [1:0]       r_st, n_st;
    logic             r_full;
    logic [95:0]      r_out;
    logic [MEM_AW-1:0] w_ra, w_wa;
    logic [31:0]      w_wd;
    logic             w_we;
    logic [PC_W-1:0]  w_pc1, w_pc2, w_immpc;
    logic             w_busy;
    logic [31:0]      w_quo, w_rem;
    logic [31:0]      r_mul;
    logic [4:0]       w_sh;

    sme_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_a(r_opa), .i_b(r_acc), .o_busy(w_busy), .o_quo(w_quo), .o_rem(w_rem)
    );

    always_comb begin
        unique case (i_cmd.asel)
            A_SP:   w_ra = r_sp[MEM_AW-1:0];
            A_SPM1: w_ra = MEM_AW'(r_sp - 13'd1);
            A_SPP1: w_ra = MEM_AW'(r_sp + 13'd1);
            A_ACC:  w_ra = r_acc[MEM_AW-1:0];
            A_OPA:  w_ra = r_opa[MEM_AW-1:0];
            A_HOST: w_ra = r_haddr;
            A_BP:   w_ra = r_bp[MEM_AW-1:0];
            A_BPP1: w_ra = MEM_AW'(r_bp + 13'd1);
            default: w_ra = r_sp[MEM_AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= mem[w_ra];
        if (w_we) mem[w_wa] <= w_wd;
    end

    assign w_pc1   = r_pc + PC_W'(1);
    assign w_pc2   = r_pc + PC_W'(2);
    assign w_immpc = r_imm[PC_W-1:0];
    assign w_sh    = r_acc[4:0];

    // Memory write: pushes land at sp-1, stores at the popped address, host writes at addr.
    always_comb begin
        w_we = i_cmd.wr;
        w_wa = r_sp[MEM_AW-1:0];
        w_wd = r_acc;
        unique case (t_op'(r_func))
            OP_CALL: begin w_wa = MEM_AW'(r_sp - 13'd1); w_wd = 32'(w_pc2); end
            OP_ENT:  begin w_wa = MEM_AW'(r_sp - 13'd1); w_wd = 32'(r_bp); end
            OP_PUSH: begin w_wa = MEM_AW'(r_sp - 13'd1); w_wd = r_acc; end
            OP_SI:   begin w_wa = r_opa[MEM_AW-1:0]; w_wd = r_acc; end
            OP_SC:   begin w_wa = r_opa[MEM_AW-1:0]; w_wd = {r_opb[31:8], r_acc[7:0]}; end
            OP_HWR:  begin w_wa = r_haddr; w_wd = r_imm; end
            default: ;
        endcase
    end

    // The popped word is in r_rdata while operand A is captured, so the
    // product is ready when the instruction executes.
    always_ff @(posedge i_clk) r_mul <= r_rdata * r_acc;

    always_comb begin
        n_acc = r_acc; n_sp = r_sp; n_bp = r_bp; n_pc = r_pc; n_halt = r_halt;
        n_exit = '0; n_st = ST_OK;
        if (t_op'(r_func) == OP_HWR) begin
        end else if (r_halt) begin
            n_st = ST_HALT;
        end else if (!known_op(r_func)) begin
            n_st = ST_BAD;
        end else if (r_func >= 6'd14 && r_func <= 6'd29) begin
            n_sp = r_sp + 13'd1;
            n_pc = w_pc1;
            unique case (t_op'(r_func))
                OP_OR:  n_acc = r_opa | r_acc;
                OP_XOR: n_acc = r_opa ^ r_acc;
                OP_AND: n_acc = r_opa & r_acc;
                OP_EQ:  n_acc = {31'd0, r_opa == r_acc};
                OP_NE:  n_acc = {31'd0, r_opa != r_acc};
                OP_LT:  n_acc = {31'd0, $signed(r_opa) < $signed(r_acc)};
                OP_GT:  n_acc = {31'd0, $signed(r_opa) > $signed(r_acc)};
                OP_LE:  n_acc = {31'd0, $signed(r_opa) <= $signed(r_acc)};
                OP_GE:  n_acc = {31'd0, $signed(r_opa) >= $signed(r_acc)};
                OP_SHL: n_acc = r_opa << w_sh;
                OP_SHR: n_acc = 32'($signed(r_opa) >>> w_sh);
                OP_ADD: n_acc = r_opa + r_acc;
                OP_SUB: n_acc = r_opa - r_acc;
                OP_MUL: n_acc = r_mul;
                default: begin
                    if (r_acc == '0) begin
                        n_acc = '0; n_st = ST_DIV0;
                    end else begin
                        n_acc = (t_op'(r_func) == OP_MOD) ? w_rem : w_quo;
                    end
                end
            endcase
        end else begin
            unique case (t_op'(r_func))
                OP_LEA:  begin n_acc = 32'(r_bp) + r_imm; n_pc = w_pc2; end
                OP_IMM:  begin n_acc = r_imm; n_pc = w_pc2; end
                OP_JMP:  n_pc = w_immpc;
                OP_CALL: begin n_sp = r_sp - 13'd1; n_pc = w_immpc; end
                OP_JZ:   n_pc = (r_acc == '0) ? w_immpc : w_pc2;
                OP_JNZ:  n_pc = (r_acc != '0) ? w_immpc : w_pc2;
                OP_ENT:  begin
                    n_bp = r_sp - 13'd1;
                    n_sp = 13'(r_sp - 13'd1 - r_imm[12:0]);
                    n_pc = w_pc2;
                end
                OP_ADJ:  begin n_sp = r_sp + r_imm[12:0]; n_pc = w_pc2; end
                OP_LEV:  begin
                    n_sp = r_bp + 13'd2;
                    n_bp = r_opa[12:0];
                    n_pc = r_opb[PC_W-1:0];
                end
                OP_LI:   begin n_acc = r_opa; n_pc = w_pc1; end
                OP_LC:   begin n_acc = {{24{r_opa[7]}}, r_opa[7:0]}; n_pc = w_pc1; end
                OP_SI, OP_SC: begin n_sp = r_sp + 13'd1; n_pc = w_pc1; end
                OP_PUSH: begin n_sp = r_sp - 13'd1; n_pc = w_pc1; end
                OP_EXIT: begin
                    n_exit = r_opa; n_halt = 1'b1; n_st = ST_HALT; n_pc = w_pc1;
                end
                default: n_st = ST_BAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0; r_sp <= 13'd4096; r_bp <= 13'd4096; r_pc <= '0;
            r_halt <= 1'b0; r_full <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sp <= i_cfg_data; r_bp <= i_cfg_data;
            end else if (i_cmd.exec) begin
                r_acc <= n_acc; r_sp <= n_sp; r_bp <= n_bp; r_pc <= n_pc;
                r_halt <= n_halt;
            end
            if (i_cmd.out_load) r_full <= 1'b1;
            else if (i_out_take) r_full <= 1'b0;
        end
        if (i_cmd.load) begin
            r_func <= i_func; r_imm <= i_imm; r_haddr <= i_addr[MEM_AW-1:0];
        end
        if (i_cmd.cap1) r_opa <= r_rdata;
        if (i_cmd.cap2) r_opb <= r_rdata;
        if (i_cmd.exec) begin r_exit <= n_exit; r_st <= n_st; end
        if (i_cmd.out_load)
            r_out <= {1'b0, r_st, r_exit, r_sp, r_pc, r_acc};
    end

    assign o_sts = '{op: t_op'(r_func), halted: r_halt, div_busy: w_busy,
                     div_zero: (r_acc == '0), out_full: r_full};
    assign o_out = r_out;
endmodule

/* sv/sme_ctrl.sv */
// Controller state machine sequencing memory reads, execution and writes.
// Depends on sme_pkg.
module sme_ctrl
    import sme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    input  logic i_out_take,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic   w_binop, w_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign w_binop  = (i_sts.op >= OP_OR) && (i_sts.op <= OP_MOD);
    assign w_active = !i_sts.halted && known_op(i_sts.op);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.asel = A_SP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_EXEC;
                if (i_sts.op == OP_HWR) n_state = S_WR;
                else if (w_active) begin
                    if (w_binop || i_sts.op == OP_SI || i_sts.op == OP_SC
                        || i_sts.op == OP_EXIT) begin
                        o_cmd.rd = 1'b1; o_cmd.asel = A_SP; n_state = S_RD1W;
                    end else if (i_sts.op == OP_LI || i_sts.op == OP_LC) begin
                        o_cmd.rd = 1'b1; o_cmd.asel = A_ACC; n_state = S_RD1W;
                    end else if (i_sts.op == OP_LEV) begin
                        o_cmd.rd = 1'b1; o_cmd.asel = A_SP; n_state = S_RD1;
                    end else if (i_sts.op == OP_CALL || i_sts.op == OP_ENT
                                 || i_sts.op == OP_PUSH) begin
                        n_state = S_WR;
                    end
                end
            end
            // LEV: the frame words at bp and bp+1 are read back to back; the
            // address slots are remapped to the base pointer outside.
            S_RD1: begin
                o_cmd.cap1 = 1'b1;
                n_state = S_RD2W;
            end
            S_RD2: begin
                n_state = S_RD2W;
            end
            S_RD2W: begin
                o_cmd.cap2 = 1'b1;
                n_state = S_EXEC;
            end
            S_RD1W: begin
                o_cmd.cap1 = 1'b1;
                if (i_sts.op == OP_SC) begin
                    n_state = S_RD2;
                end else if ((i_sts.op == OP_DIV || i_sts.op == OP_MOD)
                             && !i_sts.div_zero) begin
                    n_state = S_DIV;
                end else n_state = S_EXEC;
            end
            S_DIV: begin
                n_state = S_EXEC;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.div_busy) begin
                    o_cmd.exec = 1'b1;
                    if (w_active && (i_sts.op == OP_SI || i_sts.op == OP_SC))
                        o_cmd.wr = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_full || i_out_take) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Address overrides for second reads and the divider start.
        if (r_state == S_RD1) begin
            o_cmd.rd = 1'b1; o_cmd.asel = A_SPP1;
        end
        if (r_state == S_RD2) begin
            o_cmd.rd = 1'b1;
            o_cmd.asel = A_OPA;
        end
        if (r_state == S_DIV) o_cmd.div_start = 1'b1;
    end
endmodule

/* sv/sme_lev.sv */
// Frame-word address helper for LEV: selects base-pointer based read slots.
// Depends on sme_pkg.
module sme_lev
    import sme_pkg::*;
(
    input  t_cmd i_cmd,
    input  t_op  i_op,
    output t_cmd o_cmd
);
    // LEV reads bp and bp+1; the controller issues these in the A_SP and
    // A_SPP1 slots, so here the address source is remapped.
    always_comb begin
        o_cmd = i_cmd;
        if (i_op == OP_LEV && i_cmd.rd) begin
            if (i_cmd.asel == A_SP) o_cmd.asel = A_BP;
            else if (i_cmd.asel == A_SPP1) o_cmd.asel = A_BPP1;
        end
    end
endmodule

/* bench/tb_stack_machine_executor_top.sv */
// Self-checking bench for stack_machine_executor_top: a scoreboard class predicts each
// result from its own copy of the machine state and checks the output beats.
// Depends on sme_pkg and the top level only.
`timescale 1ns / 1ps

module tb_stack_machine_executor_top
    import sme_pkg::*;
();

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] exit_value;
        logic [12:0] stack_index;
        logic [15:0] next_pc;
        logic [31:0] acc_value;
    } t_result;

    class machine_scoreboard;
        logic [31:0] acc;
        logic [12:0] sp;
        logic [12:0] bp;
        logic [15:0] pc;
        logic        halted;
        logic [31:0] mem [MEM_WORDS];
        bit          written [MEM_WORDS];
        t_result     expected_q[$];
        int          errors;

        function void reset_state();
            acc    = '0;
            sp     = 13'd4096;
            bp     = 13'd4096;
            pc     = '0;
            halted = 1'b0;
            errors = 0;
        endfunction

        function void load_stack_top(logic [12:0] v);
            sp = v;
            bp = v;
        endfunction

        function logic [31:0] pop();
            logic [31:0] v;
            v  = mem[sp[11:0]];
            sp = sp + 13'd1;
            return v;
        endfunction

        function void push(logic [31:0] v);
            sp = sp - 13'd1;
            mem[sp[11:0]] = v;
            written[sp[11:0]] = 1'b1;
        endfunction

        // Words the next instruction reads, so that the bench can write them
        // first; the second word of SC is only valid once the first is written.
        function int read_addrs(logic [5:0] f, output logic [11:0] r0,
                                output logic [11:0] r1);
            logic [12:0] bp1;
            r0  = sp[11:0];
            r1  = sp[11:0];
            bp1 = bp + 13'd1;
            if (halted || f == OP_HWR)
                return 0;
            if ((f >= OP_OR && f <= OP_MOD) || f == OP_SI || f == OP_EXIT)
                return 1;
            if (f == OP_SC) begin
                r1 = mem[sp[11:0]][11:0];
                return 2;
            end
            if (f == OP_LI || f == OP_LC) begin
                r0 = acc[11:0];
                return 1;
            end
            if (f == OP_LEV) begin
                r0 = bp[11:0];
                r1 = bp1[11:0];
                return 2;
            end
            return 0;
        endfunction

        // Signed divide on magnitudes so that the most negative value over
        // minus one wraps instead of overflowing.
        function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
            logic [31:0] ua, ub, q, r;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q  = ua / ub;
            r  = ua % ub;
            if (want_rem)
                return a[31] ? -r : r;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_instruction(logic [5:0] f, logic [31:0] imm, logic [11:0] addr);
            t_result     e;
            logic [31:0] a, ax;
            logic [4:0]  sh;
            logic [15:0] pc1, pc2;
            e   = '0;
            ax  = acc;
            pc1 = pc + 16'd1;
            pc2 = pc + 16'd2;
            if (f == OP_HWR) begin
                mem[addr] = imm;
                written[addr] = 1'b1;
            end else if (halted) begin
                e.status = ST_HALT;
            end else if (f >= OP_OR && f <= OP_MOD) begin
                a  = pop();
                sh = ax[4:0];
                case (f)
                    OP_OR:  ax = a | ax;
                    OP_XOR: ax = a ^ ax;
                    OP_AND: ax = a & ax;
                    OP_EQ:  ax = (a == ax);
                    OP_NE:  ax = (a != ax);
                    OP_LT:  ax = ($signed(a) < $signed(ax));
                    OP_GT:  ax = ($signed(a) > $signed(ax));
                    OP_LE:  ax = ($signed(a) <= $signed(ax));
                    OP_GE:  ax = ($signed(a) >= $signed(ax));
                    OP_SHL: ax = a << sh;
                    OP_SHR: ax = $signed(a) >>> sh;
                    OP_ADD: ax = a + ax;
                    OP_SUB: ax = a - ax;
                    OP_MUL: ax = a * ax;
                    default: begin
                        if (ax == 0) begin
                            e.status = ST_DIV0;
                        end else begin
                            ax = sdiv(a, ax, f == OP_MOD);
                        end
                    end
                endcase
                pc = pc1;
            end else begin
                case (f)
                    OP_LEA: begin ax = {19'd0, bp} + imm; pc = pc2; end
                    OP_IMM: begin ax = imm; pc = pc2; end
                    OP_JMP: pc = imm[15:0];
                    OP_CALL: begin push({16'd0, pc2}); pc = imm[15:0]; end
                    OP_JZ:  pc = (ax == 0) ? imm[15:0] : pc2;
                    OP_JNZ: pc = (ax != 0) ? imm[15:0] : pc2;
                    OP_ENT: begin
                        push({19'd0, bp});
                        bp = sp;
                        sp = sp - imm[12:0];
                        pc = pc2;
                    end
                    OP_ADJ: begin sp = sp + imm[12:0]; pc = pc2; end
                    OP_LEV: begin
                        sp = bp;
                        a  = pop();
                        bp = a[12:0];
                        a  = pop();
                        pc = a[15:0];
                    end
                    OP_LI: begin ax = mem[ax[11:0]]; pc = pc1; end
                    OP_LC: begin
                        ax = {{24{mem[ax[11:0]][7]}}, mem[ax[11:0]][7:0]};
                        pc = pc1;
                    end
                    OP_SI: begin
                        a = pop();
                        mem[a[11:0]] = ax;
                        written[a[11:0]] = 1'b1;
                        pc = pc1;
                    end
                    OP_SC: begin a = pop(); mem[a[11:0]][7:0] = ax[7:0]; pc = pc1; end
                    OP_PUSH: begin push(ax); pc = pc1; end
                    OP_EXIT: begin
                        e.exit_value = mem[sp[11:0]];
                        halted   = 1'b1;
                        e.status = ST_HALT;
                        pc       = pc1;
                    end
                    default: e.status = ST_BAD;
                endcase
            end
            acc           = ax;
            e.acc_value   = acc;
            e.next_pc     = pc;
            e.stack_index = sp;
            expected_q.push_back(e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.acc_value !== e.acc_value)
                $display("%0t: acc_value exp %h got %h", $time, e.acc_value, got.acc_value);
            if (got.next_pc !== e.next_pc)
                $display("%0t: next_pc exp %h got %h", $time, e.next_pc, got.next_pc);
            if (got.stack_index !== e.stack_index)
                $display("%0t: stack_index exp %h got %h", $time, e.stack_index,
                         got.stack_index);
            if (got.exit_value !== e.exit_value)
                $display("%0t: exit_value exp %h got %h", $time, e.exit_value,
                         got.exit_value);
            if (got.status !== e.status)
                $display("%0t: status exp %h got %h", $time, e.status, got.status);
            if (got !== e)
                errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;

    machine_scoreboard sb = new();
    bit no_idle;
    bit hold_go;

    always #5 i_clk = ~i_clk;

    stack_machine_executor_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Receiver: random back-pressure, one long hold-off once asked for.
    int hold_cnt = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[94:0]);
        if (hold_go && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 400)
                hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    // Writes any word that the next instruction would read before it is set.
    task automatic cover_reads(logic [5:0] f);
        logic [11:0] r0, r1;
        int          n;
        repeat (2) begin
            n = sb.read_addrs(f, r0, r1);
            if (n > 0 && !sb.written[r0])
                send_instr(OP_HWR, $urandom, r0);
            else if (n > 1 && !sb.written[r1])
                send_instr(OP_HWR, $urandom, r1);
        end
    endtask

    task automatic send_instr(logic [5:0] f, logic [31:0] imm, logic [11:0] addr);
        cover_reads(f);
        if (!no_idle && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, addr, imm, f};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_instruction(f, imm, addr);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_stack_top(logic [12:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.load_stack_top(v);
    endtask

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'hffff_ffff;
            default: return $urandom_range(0, 12) - 4;
        endcase
    endfunction

    task automatic random_instrs(int n);
        logic [5:0] f;
        int         r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 8)
                f = OP_HWR;
            else if (r < 13)
                f = (r < 10) ? 6'($urandom_range(30, 36)) : 6'($urandom_range(39, 63));
            else
                f = 6'($urandom_range(OP_LEA, OP_MOD));
            send_instr(f, rand_imm(), 12'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sb.reset_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, wrap cases, byte access, divide by zero.
        send_instr(OP_HWR, 32'hffff_ffff, 12'hfff);
        send_instr(OP_IMM, 32'h8000_0000, 12'hfff);
        send_instr(OP_PUSH, 0, 0);
        send_instr(OP_IMM, 32'hffff_ffff, 0);
        send_instr(OP_DIV, 0, 0);
        send_instr(OP_PUSH, 0, 0);
        send_instr(OP_IMM, 0, 0);
        send_instr(OP_MOD, 0, 0);
        send_instr(OP_LEA, 32'h7fff_ffff, 0);
        send_instr(OP_IMM, 32'h0000_0fff, 0);
        send_instr(OP_LC, 0, 0);
        send_instr(OP_PUSH, 0, 0);
        send_instr(OP_IMM, 32'h0000_0031, 0);
        send_instr(OP_SHR, 0, 0);
        send_instr(OP_CALL, 32'h0001_fffe, 0);
        send_instr(OP_ENT, 3, 0);
        send_instr(OP_LEV, 0, 0);
        send_instr(OP_JZ, 32'hffff_ffff, 0);
        send_instr(OP_JNZ, 32'h1234, 0);
        send_instr(6'd30, 0, 0);
        send_instr(6'd63, 0, 0);

        write_stack_top(13'd1);
        random_instrs(200);
        write_stack_top(13'd4096);
        hold_go = 1'b1;
        random_instrs(200);
        write_stack_top(13'($urandom_range(1, 4096)));
        no_idle = 1'b1;
        random_instrs(150);
        no_idle = 1'b0;
        write_stack_top(13'($urandom_range(1, 4096)));
        random_instrs(200);

        // Halt, then check that only host writes and the stack-top write still act.
        send_instr(OP_EXIT, 0, 0);
        send_instr(OP_IMM, 5, 0);
        send_instr(OP_HWR, 32'h8000_0000, 12'h000);
        send_instr(OP_PUSH, 0, 0);
        send_instr(OP_EXIT, 0, 0);
        write_stack_top(13'd4096);
        send_instr(OP_ADD, 0, 0);
        drain();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/sme_pkg.sv
sv/sme_div.sv
sv/sme_datapath.sv
sv/sme_ctrl.sv
sv/sme_lev.sv
sv/stack_machine_executor_top.sv
bench/tb_stack_machine_executor_top.sv
